// File: src/tmd_pkg.sv
// Shared types, constants and datapath step functions for the move duration pipeline.
`timescale 1ns / 1ps
package tmd_pkg;

  localparam int unsigned LenW   = 24;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DvdW   = 59;
  localparam int unsigned DvsW   = 34;
  localparam int unsigned RadW   = 56;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned SRemW  = RootW + 2;
  localparam int unsigned DivSteps  = DvdW;
  localparam int unsigned SqrtSteps = RootW;

  localparam logic CfgFeed  = 1'b0;
  localparam logic CfgAccel = 1'b1;

  localparam logic [CfgW-1:0] FeedReset  = 16'd3000;
  localparam logic [CfgW-1:0] AccelReset = 16'd500;

  localparam logic [31:0] SqrtScale  = 32'd4000000000;
  localparam logic [15:0] CruiseFf   = 16'd50000;
  localparam logic [17:0] CruiseLa   = 18'd180000;

  typedef struct packed {
    logic zero;
    logic inf;
    logic cruise;
  } tmd_flags_t;

  typedef struct packed {
    tmd_flags_t            f;
    logic [DvsW-1:0]       rem;
    logic [DvsW-1:0]       dvs;
    logic [DvdW-1:0]       dq;
  } div_stage_t;

  typedef struct packed {
    tmd_flags_t            f;
    logic                  sat;
    logic [TimeW-1:0]      res;
    logic [SRemW-1:0]      rem;
    logic [RootW-1:0]      root;
    logic [RadW-1:0]       x;
  } sqrt_stage_t;

  // one restoring division step: remainder and dividend/quotient shift together
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t  o;
    logic [DvsW:0] t;
    logic        b;
    o = s;
    t = {s.rem, s.dq[DvdW-1]};
    b = (t >= {1'b0, s.dvs});
    if (b) begin
      t = t - {1'b0, s.dvs};
    end
    o.rem = t[DvsW-1:0];
    o.dq  = {s.dq[DvdW-2:0], b};
    return o;
  endfunction

  // one digit-by-digit square root step, two radicand bits per step
  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t s);
    sqrt_stage_t    o;
    logic [SRemW-1:0] t;
    logic [SRemW-1:0] trial;
    logic           b;
    o = s;
    t     = {s.rem[SRemW-3:0], s.x[RadW-1:RadW-2]};
    trial = {s.root, 2'b01};
    b     = (t >= trial);
    if (b) begin
      t = t - trial;
    end
    o.rem  = t;
    o.root = {s.root[RootW-2:0], b};
    o.x    = {s.x[RadW-3:0], 2'b00};
    return o;
  endfunction

endpackage

// File: src/tmd_stream_if.sv
// Valid/ready stream channel with a flat payload.
`timescale 1ns / 1ps
interface tmd_stream_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/trapezoid_move_duration.sv
// Stages: 2 product stages, 59 divide, 28 root, 1 out.
// Throughput: one move per cycle while the output is not stalled; each divide and root step is its own register stage.
// Stalls freeze the whole pipeline; input ready follows output space.
// Reset: asynchronous active low, clears stage valids; feed 3000, accel 500.
// Zero length gives 0; zero feed or accel with nonzero length saturates.
`timescale 1ns / 1ps
module trapezoid_move_duration (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  tmd_stream_if.sink          in_ch,
  tmd_stream_if.source        out_ch
);

  logic [tmd_pkg::CfgW-1:0] feed_q, accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_q  <= tmd_pkg::FeedReset;
      accel_q <= tmd_pkg::AccelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmd_pkg::CfgFeed:  feed_q  <= cfg_data_i;
        tmd_pkg::CfgAccel: accel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign en          = !out_v_q || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: raw products
  logic                s1_v_q;
  tmd_pkg::tmd_flags_t s1_f_q;
  logic [31:0]         s1_ff_q, s1_af_q;
  logic [39:0]         s1_la_q;
  logic [55:0]         s1_lx_q;
  logic [15:0]         s1_a_q;
  logic [23:0]         len;

  assign len = in_ch.data[tmd_pkg::LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_ch.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_f_q.zero   <= (len == '0);
      s1_f_q.inf    <= (feed_q == '0) || (accel_q == '0);
      s1_f_q.cruise <= 1'b0;
      s1_ff_q <= feed_q * feed_q;
      s1_af_q <= accel_q * feed_q;
      s1_la_q <= len * accel_q;
      s1_lx_q <= len * tmd_pkg::SqrtScale;
      s1_a_q  <= accel_q;
    end
  end

  // stage 2: numerator, denominator, branch select
  logic                s2_v_q;
  tmd_pkg::div_stage_t s2_q;
  logic [58:0]         num;
  logic [44:0]         la18;
  logic [34:0]         ff5;
  logic                cruise;

  assign num    = 59'(s1_ff_q) * 59'(tmd_pkg::CruiseFf) + 59'(s1_la_q) * 59'(tmd_pkg::CruiseLa);
  assign la18   = 45'(s1_la_q) * 45'd18;
  assign ff5    = 35'(s1_ff_q) * 35'd5;
  assign cruise = (la18 > 45'(ff5));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.f.zero   <= s1_f_q.zero;
      s2_q.f.inf    <= s1_f_q.inf;
      s2_q.f.cruise <= cruise;
      s2_q.rem      <= '0;
      if (s1_f_q.inf) begin
        s2_q.dvs <= 34'd1;
        s2_q.dq  <= '0;
      end else if (cruise) begin
        s2_q.dvs <= 34'(s1_af_q) * 34'd3;
        s2_q.dq  <= num;
      end else begin
        s2_q.dvs <= 34'(s1_a_q);
        s2_q.dq  <= 59'(s1_lx_q);
      end
    end
  end

  // divider: one quotient bit per stage
  logic                dv_v_q [tmd_pkg::DivSteps];
  tmd_pkg::div_stage_t dv_q   [tmd_pkg::DivSteps];

  for (genvar k = 0; k < tmd_pkg::DivSteps; k++) begin : g_div
    logic                prev_v;
    tmd_pkg::div_stage_t prev;
    if (k == 0) begin : g_first
      assign prev_v = s2_v_q;
      assign prev   = s2_q;
    end else begin : g_next
      assign prev_v = dv_v_q[k-1];
      assign prev   = dv_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else if (en) dv_v_q[k] <= prev_v;
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[k] <= tmd_pkg::div_step(prev);
    end
  end

  // square root entry
  tmd_pkg::div_stage_t  dv_last;
  tmd_pkg::sqrt_stage_t sq_in;
  assign dv_last = dv_q[tmd_pkg::DivSteps-1];

  always_comb begin
    sq_in.f    = dv_last.f;
    sq_in.sat  = (dv_last.dq[58:32] != '0);
    sq_in.res  = dv_last.dq[31:0];
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.x    = dv_last.dq[55:0];
  end

  logic                 sq_v_q [tmd_pkg::SqrtSteps];
  tmd_pkg::sqrt_stage_t sq_q   [tmd_pkg::SqrtSteps];

  for (genvar k = 0; k < tmd_pkg::SqrtSteps; k++) begin : g_sqrt
    logic                 prev_v;
    tmd_pkg::sqrt_stage_t prev;
    if (k == 0) begin : g_first
      assign prev_v = dv_v_q[tmd_pkg::DivSteps-1];
      assign prev   = sq_in;
    end else begin : g_next
      assign prev_v = sq_v_q[k-1];
      assign prev   = sq_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else if (en) sq_v_q[k] <= prev_v;
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[k] <= tmd_pkg::sqrt_step(prev);
    end
  end

  // output register
  tmd_pkg::sqrt_stage_t sq_last;
  logic [31:0]          time_d, time_q;
  logic                 sat_d, sat_q;
  assign sq_last = sq_q[tmd_pkg::SqrtSteps-1];

  always_comb begin
    priority if (sq_last.f.zero) begin
      time_d = '0;
      sat_d  = 1'b0;
    end else if (sq_last.f.inf || (sq_last.f.cruise && sq_last.sat)) begin
      time_d = '1;
      sat_d  = 1'b1;
    end else if (sq_last.f.cruise) begin
      time_d = sq_last.res;
      sat_d  = 1'b0;
    end else begin
      time_d = 32'(sq_last.root);
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= sq_v_q[tmd_pkg::SqrtSteps-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      time_q <= time_d;
      sat_q  <= sat_d;
    end
  end

  assign out_ch.valid = out_v_q;
  assign out_ch.data  = {sat_q, time_q};

`ifndef SYNTHESIS
  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && sat_q) |-> (time_q == '1))
    else $error("saturated beat without clamped time");

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> s1_v_q)
    else $error("accepted beat missing from first stage");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[tmd_pkg::DivSteps-1] |-> (dv_last.rem < dv_last.dvs))
    else $error("divider remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sq_v_q[tmd_pkg::SqrtSteps-1]) && $stable(dv_v_q[0])))
    else $error("pipeline moved during stall");
`endif

endmodule
